// ===== rtl/core/rct_pkg.sv =====
// Package: register codes, mode bits and types for the root counter timers.
package rct_pkg;

    localparam int NUM_TIMERS = 3;
    localparam int IDX_W      = 2;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_WR_COUNT  = 3'd1,
        OP_WR_MODE   = 3'd2,
        OP_WR_TARGET = 3'd3,
        OP_RD_COUNT  = 3'd4,
        OP_RD_MODE   = 3'd5,
        OP_RD_TARGET = 3'd6,
        OP_NONE      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        CFG_CYCLES_PER_LINE = 2'd0,
        CFG_LINES_PER_FRAME = 2'd1,
        CFG_VBLANK_START    = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] M_DISABLE    = 16'h0001;
    localparam logic [15:0] M_TO_TARGET  = 16'h0008;
    localparam logic [15:0] M_IRQ_TARGET = 16'h0010;
    localparam logic [15:0] M_IRQ_OVF    = 16'h0020;
    localparam logic [15:0] M_IRQ_REPEAT = 16'h0040;
    localparam logic [15:0] M_CLK_A      = 16'h0100;
    localparam logic [15:0] M_CLK_B      = 16'h0200;
    localparam logic [15:0] M_IRQ_REQ    = 16'h0400;
    localparam logic [15:0] M_HIT_TARGET = 16'h0800;
    localparam logic [15:0] M_HIT_OVF    = 16'h1000;
    localparam logic [15:0] M_READ_CLEAR = 16'he7ff;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;

    localparam logic [15:0] RST_CYCLES_PER_LINE = 16'd2146;
    localparam logic [9:0]  RST_LINES_PER_FRAME = 10'd263;
    localparam logic [9:0]  RST_VBLANK_START    = 10'd243;

endpackage

// ===== rtl/core/root_counter_timers_core.sv =====
// Root counter timers: three 16-bit timers plus a scanline base counter.
// An accepted input beat's result beat is registered and shown in the next cycle.
// Throughput: one beat per cycle while out_ready is high; the single output
// register refills in the cycle it is drained; state update sets the rate.
// Reset: rst_n asynchronously clears all timers, the base counter and the
// output valid flag, and loads the default line and frame configuration.
module root_counter_timers_core
    import rct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [1:0]  counter_index,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] read_data,
    output logic [2:0]  timer_irq,
    output logic        frame_irq,
    output logic        vblank_level,
    output logic        hsync_pulse
);

    logic [15:0] cycles_per_line_reg;
    logic [9:0]  lines_per_frame_reg;
    logic [9:0]  vblank_start_reg;

    logic [15:0] count_reg    [NUM_TIMERS];
    logic [15:0] prescale_reg [NUM_TIMERS];
    logic [15:0] mode_reg     [NUM_TIMERS];
    logic [15:0] target_reg   [NUM_TIMERS];
    logic        heading_reg  [NUM_TIMERS];
    logic        raised_reg   [NUM_TIMERS];
    logic [15:0] line_cyc_reg;
    logic [9:0]  line_num_reg;
    logic        vblank_reg;

    logic [15:0] count_next    [NUM_TIMERS];
    logic [15:0] prescale_next [NUM_TIMERS];
    logic [15:0] mode_next     [NUM_TIMERS];
    logic [15:0] target_next   [NUM_TIMERS];
    logic        heading_next  [NUM_TIMERS];
    logic        raised_next   [NUM_TIMERS];
    logic [15:0] line_cyc_next;
    logic [9:0]  line_num_next;
    logic        vblank_next;

    logic        out_valid_reg;
    logic [15:0] rd_reg, rd_next;
    logic [2:0]  irq_reg, irq_next;
    logic        frame_reg, frame_next;
    logic        hsync_reg, hsync_next;

    logic        accept;
    op_t         op;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign op        = op_t'(operation);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_per_line_reg <= RST_CYCLES_PER_LINE;
            lines_per_frame_reg <= RST_LINES_PER_FRAME;
            vblank_start_reg    <= RST_VBLANK_START;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CYCLES_PER_LINE: cycles_per_line_reg <= cfg_data;
                CFG_LINES_PER_FRAME: lines_per_frame_reg <= cfg_data[9:0];
                CFG_VBLANK_START:    vblank_start_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Timer and base counter update for one beat
    always_comb
    begin
        logic [15:0] rate;
        logic [16:0] p;
        logic [16:0] nx;
        logic [15:0] c;
        logic        sel;
        logic [16:0] lc;
        logic [9:0]  ln;

        rd_next       = '0;
        irq_next      = '0;
        frame_next    = 1'b0;
        hsync_next    = 1'b0;
        line_cyc_next = line_cyc_reg;
        line_num_next = line_num_reg;
        vblank_next   = vblank_reg;
        rate = '0; p = '0; nx = '0; c = '0; sel = 1'b0; lc = '0; ln = '0;

        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            count_next[i]    = count_reg[i];
            prescale_next[i] = prescale_reg[i];
            mode_next[i]     = mode_reg[i];
            target_next[i]   = target_reg[i];
            heading_next[i]  = heading_reg[i];
            raised_next[i]   = raised_reg[i];
            sel = (counter_index == IDX_W'(i));

            if (op == OP_TICK)
            begin
                if (i == 0)
                    rate = ((mode_reg[i] & M_CLK_A) != '0) ? 16'd5 : 16'd1;
                else if (i == 1)
                    rate = ((mode_reg[i] & M_CLK_A) != '0) ? cycles_per_line_reg : 16'd1;
                else
                    rate = ((mode_reg[i] & M_CLK_B) != '0) ? 16'd8 : 16'd1;
                p = {1'b0, prescale_reg[i]} + 17'd1;
                if (i == 2 && (mode_reg[i] & M_DISABLE) != '0)
                begin
                    // frozen
                end
                else if (p < {1'b0, rate})
                begin
                    prescale_next[i] = p[15:0];
                end
                else
                begin
                    prescale_next[i] = '0;
                    nx = {1'b0, count_reg[i]} + 17'd1;
                    if (heading_reg[i] && nx >= {1'b0, target_reg[i]})
                    begin
                        if ((mode_reg[i] & M_TO_TARGET) != '0)
                            nx = nx - {1'b0, target_reg[i]};
                        c = nx[15:0];
                        count_next[i]   = c;
                        heading_next[i] = c < target_reg[i];
                        if ((mode_reg[i] & M_IRQ_TARGET) != '0 &&
                            ((mode_reg[i] & M_IRQ_REPEAT) != '0 || !raised_reg[i]))
                        begin
                            raised_next[i] = 1'b1;
                            irq_next[i]    = 1'b1;
                        end
                        mode_next[i] = mode_reg[i] | M_HIT_TARGET | M_IRQ_REQ;
                    end
                    else if (!heading_reg[i] && nx >= {1'b0, COUNT_MAX})
                    begin
                        nx = nx - {1'b0, COUNT_MAX};
                        c = nx[15:0];
                        count_next[i]   = c;
                        heading_next[i] = c < target_reg[i];
                        if ((mode_reg[i] & M_IRQ_OVF) != '0 &&
                            ((mode_reg[i] & M_IRQ_REPEAT) != '0 || !raised_reg[i]))
                        begin
                            raised_next[i] = 1'b1;
                            irq_next[i]    = 1'b1;
                        end
                        mode_next[i] = mode_reg[i] | M_HIT_OVF | M_IRQ_REQ;
                    end
                    else
                    begin
                        count_next[i] = nx[15:0];
                    end
                end
            end
            else if (sel)
            begin
                unique case (op)
                    OP_WR_COUNT:
                    begin
                        count_next[i]    = write_data;
                        prescale_next[i] = '0;
                        heading_next[i]  = write_data < target_reg[i];
                    end
                    OP_WR_MODE:
                    begin
                        mode_next[i]     = write_data;
                        raised_next[i]   = 1'b0;
                        count_next[i]    = '0;
                        prescale_next[i] = '0;
                        heading_next[i]  = 16'd0 < target_reg[i];
                    end
                    OP_WR_TARGET:
                    begin
                        target_next[i]   = write_data;
                        prescale_next[i] = '0;
                        heading_next[i]  = count_reg[i] < write_data;
                    end
                    OP_RD_COUNT:  rd_next = count_reg[i];
                    OP_RD_MODE:
                    begin
                        rd_next      = mode_reg[i];
                        mode_next[i] = mode_reg[i] & M_READ_CLEAR;
                    end
                    OP_RD_TARGET: rd_next = target_reg[i];
                    default: ;
                endcase
            end
        end

        // Scanline base counter
        if (op == OP_TICK)
        begin
            lc = {1'b0, line_cyc_reg} + 17'd1;
            if (lc[15:0] >= cycles_per_line_reg || lc[15:0] == 16'd0)
            begin
                line_cyc_next = '0;
                hsync_next    = 1'b1;
                ln = line_num_reg + 10'd1;
                line_num_next = ln;
                if (ln == vblank_start_reg)
                    vblank_next = 1'b1;
                if (ln >= lines_per_frame_reg)
                begin
                    line_num_next = '0;
                    vblank_next   = 1'b0;
                    frame_next    = 1'b1;
                end
            end
            else
            begin
                line_cyc_next = lc[15:0];
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]    <= '0;
                prescale_reg[i] <= '0;
                mode_reg[i]     <= '0;
                target_reg[i]   <= '0;
                heading_reg[i]  <= 1'b0;
                raised_reg[i]   <= 1'b0;
            end
            line_cyc_reg <= '0;
            line_num_reg <= '0;
            vblank_reg   <= 1'b0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]    <= count_next[i];
                prescale_reg[i] <= prescale_next[i];
                mode_reg[i]     <= mode_next[i];
                target_reg[i]   <= target_next[i];
                heading_reg[i]  <= heading_next[i];
                raised_reg[i]   <= raised_next[i];
            end
            line_cyc_reg <= line_cyc_next;
            line_num_reg <= line_num_next;
            vblank_reg   <= vblank_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg    <= rd_next;
            irq_reg   <= irq_next;
            frame_reg <= frame_next;
            hsync_reg <= hsync_next;
        end
    end

    logic vb_out_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
            vb_out_reg <= vblank_next;
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_reg;
    assign timer_irq    = irq_reg;
    assign frame_irq    = frame_reg;
    assign vblank_level = vb_out_reg;
    assign hsync_pulse  = hsync_reg;

endmodule

// ===== test/rct_checker.sv =====
// Checker for the root counter timers: predicts each result beat and compares.
`timescale 1ns / 100ps

module rct_checker
    import rct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [1:0]  counter_index,
    input  logic [15:0] write_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] read_data,
    input  logic [2:0]  timer_irq,
    input  logic        frame_irq,
    input  logic        vblank_level,
    input  logic        hsync_pulse,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [15:0] rd;
        logic [2:0]  irq;
        logic        frame;
        logic        vblank;
        logic        hsync;
    } timer_result_t;

    timer_result_t result_q[$];

    // Model state
    logic [15:0] line_len;
    logic [9:0]  frame_len;
    logic [9:0]  vb_line;
    logic [15:0] cnt     [NUM_TIMERS];
    logic [15:0] presc   [NUM_TIMERS];
    logic [15:0] mode    [NUM_TIMERS];
    logic [15:0] tgt     [NUM_TIMERS];
    logic        to_tgt  [NUM_TIMERS];
    logic        irq_done[NUM_TIMERS];
    logic [15:0] line_cyc;
    logic [9:0]  line_no;
    logic        vb;

    assign pending = result_q.size();

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [16:0] div_rate(input int i);
        if (i == 0) return (mode[0] & M_CLK_A) != 0 ? 17'd5 : 17'd1;
        if (i == 1) return (mode[1] & M_CLK_A) != 0 ? {1'b0, line_len} : 17'd1;
        return (mode[2] & M_CLK_B) != 0 ? 17'd8 : 17'd1;
    endfunction

    function automatic logic fire_irq(input int i, input logic [15:0] en);
        if ((mode[i] & en) != 0 && ((mode[i] & M_IRQ_REPEAT) != 0 || !irq_done[i])) begin
            irq_done[i] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic advance_timer(input int i);
        logic [16:0] p;
        logic [16:0] nxt;
        logic        irq;
        irq = 1'b0;
        if (i == 2 && (mode[2] & M_DISABLE) != 0) return 1'b0;
        p = presc[i] + 17'd1;
        if (p < div_rate(i)) begin
            presc[i] = p[15:0];
            return 1'b0;
        end
        presc[i] = '0;
        nxt = cnt[i] + 17'd1;
        if (to_tgt[i] && nxt >= tgt[i]) begin
            if ((mode[i] & M_TO_TARGET) != 0) nxt = nxt - tgt[i];
            cnt[i] = nxt[15:0];
            to_tgt[i] = cnt[i] < tgt[i];
            irq = fire_irq(i, M_IRQ_TARGET);
            mode[i] |= M_HIT_TARGET | M_IRQ_REQ;
        end else if (!to_tgt[i] && nxt >= COUNT_MAX) begin
            nxt = nxt - COUNT_MAX;
            cnt[i] = nxt[15:0];
            to_tgt[i] = cnt[i] < tgt[i];
            irq = fire_irq(i, M_IRQ_OVF);
            mode[i] |= M_HIT_OVF | M_IRQ_REQ;
        end else begin
            cnt[i] = nxt[15:0];
        end
        return irq;
    endfunction

    function automatic void load_count(input int i, input logic [15:0] v);
        cnt[i] = v;
        presc[i] = '0;
        to_tgt[i] = v < tgt[i];
    endfunction

    function automatic timer_result_t predict_result(input op_t op, input logic [1:0] idx,
                                                     input logic [15:0] data);
        timer_result_t r;
        r = '0;
        if (op == OP_TICK) begin
            for (int i = 0; i < NUM_TIMERS; i++)
                r.irq[i] = advance_timer(i);
            line_cyc = line_cyc + 16'd1;
            if (line_cyc >= line_len || line_cyc == 0) begin
                line_cyc = '0;
                r.hsync = 1'b1;
                line_no = line_no + 10'd1;
                if (line_no == vb_line) vb = 1'b1;
                if (line_no >= frame_len) begin
                    line_no = '0;
                    vb = 1'b0;
                    r.frame = 1'b1;
                end
            end
        end else if (idx < NUM_TIMERS) begin
            case (op)
                OP_WR_COUNT:  load_count(idx, data);
                OP_WR_MODE:
                begin
                    mode[idx] = data;
                    irq_done[idx] = 1'b0;
                    load_count(idx, 16'd0);
                end
                OP_WR_TARGET:
                begin
                    tgt[idx] = data;
                    load_count(idx, cnt[idx]);
                end
                OP_RD_COUNT:  r.rd = cnt[idx];
                OP_RD_MODE:
                begin
                    r.rd = mode[idx];
                    mode[idx] &= M_READ_CLEAR;
                end
                OP_RD_TARGET: r.rd = tgt[idx];
                default: ;
            endcase
        end
        r.vblank = vb;
        return r;
    endfunction

    // Sample the setup, input and output channels at each edge
    always @(posedge clk or negedge rst_n) begin
        timer_result_t want;
        if (!rst_n) begin
            line_len  = RST_CYCLES_PER_LINE;
            frame_len = RST_LINES_PER_FRAME;
            vb_line   = RST_VBLANK_START;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                cnt[i] = '0; presc[i] = '0; mode[i] = '0; tgt[i] = '0;
                to_tgt[i] = 1'b0; irq_done[i] = 1'b0;
            end
            line_cyc = '0;
            line_no  = '0;
            vb       = 1'b0;
            mismatches = 0;
            result_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CYCLES_PER_LINE: line_len = cfg_data;
                    CFG_LINES_PER_FRAME: frame_len = cfg_data[9:0];
                    CFG_VBLANK_START:    vb_line = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    report("unexpected beat", read_data, 0);
                end else begin
                    want = result_q.pop_front();
                    if (read_data !== want.rd) report("read_data", read_data, want.rd);
                    if (timer_irq !== want.irq) report("timer_irq", timer_irq, want.irq);
                    if (frame_irq !== want.frame) report("frame_irq", frame_irq, want.frame);
                    if (vblank_level !== want.vblank)
                        report("vblank_level", vblank_level, want.vblank);
                    if (hsync_pulse !== want.hsync)
                        report("hsync_pulse", hsync_pulse, want.hsync);
                end
            end
            if (in_valid && in_ready)
                result_q.push_back(predict_result(op_t'(operation), counter_index, write_data));
        end
    end

endmodule

// ===== test/testbench.sv =====
// Testbench top: drives timer accesses, ticks and line setup; gives the verdict.
`timescale 1ns / 100ps

module testbench;
    import rct_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [1:0]  counter_index;
    logic [15:0] write_data;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] read_data;
    logic [2:0]  timer_irq;
    logic        frame_irq;
    logic        vblank_level;
    logic        hsync_pulse;
    int          mismatches;
    int          pending;
    int          cycle_count;
    int          gap_left;

    root_counter_timers_core u_top (.*);

    rct_checker u_checker (.*);

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver stalls: mostly ready, runs of stalls now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (cycle_count % 1000 < 300) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_beat(input op_t op, input logic [1:0] idx, input logic [15:0] data);
        logic took;
        took = 1'b0;
        if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 6);
        end
        while (gap_left > 0) begin
            in_valid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        in_valid      <= 1'b1;
        operation     <= op;
        counter_index <= idx;
        write_data    <= data;
        // in_ready is settled mid-cycle; it decides acceptance at the next edge
        do begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
    endtask

    task automatic write_setup(input cfg_idx_t idx, input logic [15:0] data);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic random_beat(input int tick_weight);
        logic [1:0]  idx;
        logic [15:0] data;
        int          pick;
        idx  = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: data = 16'($urandom);
            1: data = 16'($urandom_range(0, 20));
            2: data = 16'hffff - 16'($urandom_range(0, 20));
            default: data = {$urandom_range(0, 1) ? 9'h0 : 9'($urandom), 7'($urandom)};
        endcase
        if (pick < tick_weight) send_beat(OP_TICK, idx, data);
        else send_beat(op_t'($urandom_range(1, 7)), idx, data);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_CYCLES_PER_LINE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_TICK;
        counter_index = '0;
        write_data    = '0;
        gap_left      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short lines so the frame logic moves quickly
        write_setup(CFG_CYCLES_PER_LINE, 16'd3);
        write_setup(CFG_LINES_PER_FRAME, 16'd4);
        write_setup(CFG_VBLANK_START, 16'd2);
        write_setup(CFG_UNUSED, 16'hffff);

        // Directed: every access, extremes, disable and out-of-range index
        send_beat(OP_WR_TARGET, 2'd0, 16'd3);
        send_beat(OP_WR_MODE, 2'd0, M_TO_TARGET | M_IRQ_TARGET | M_IRQ_REPEAT);
        repeat (7) send_beat(OP_TICK, 2'd3, 16'hffff);
        send_beat(OP_RD_MODE, 2'd0, 16'd0);
        send_beat(OP_RD_MODE, 2'd0, 16'd0);
        send_beat(OP_WR_MODE, 2'd1, M_IRQ_OVF | M_CLK_A);
        send_beat(OP_WR_COUNT, 2'd1, 16'hffff);
        send_beat(OP_WR_MODE, 2'd2, M_DISABLE | M_CLK_B);
        send_beat(OP_WR_COUNT, 2'd2, 16'hfffe);
        send_beat(OP_TICK, 2'd0, 16'd0);
        send_beat(OP_RD_COUNT, 2'd1, 16'd0);
        send_beat(OP_RD_COUNT, 2'd2, 16'd0);
        send_beat(OP_RD_TARGET, 2'd0, 16'd0);
        send_beat(OP_WR_COUNT, 2'd3, 16'h1234);
        send_beat(OP_RD_COUNT, 2'd3, 16'd0);
        send_beat(OP_NONE, 2'd0, 16'hffff);
        drain();

        // Zero line length and zero frame length
        write_setup(CFG_CYCLES_PER_LINE, 16'd0);
        write_setup(CFG_LINES_PER_FRAME, 16'd0);
        write_setup(CFG_VBLANK_START, 16'd0);
        for (int n = 0; n < 300; n++) random_beat(70);
        drain();

        // Small random setups; the vblank line may fall on the wrap line
        for (int ph = 0; ph < 5; ph++) begin
            write_setup(CFG_CYCLES_PER_LINE, 16'($urandom_range(1, 12)));
            write_setup(CFG_LINES_PER_FRAME, 16'($urandom_range(1, 8)));
            write_setup(CFG_VBLANK_START, 16'($urandom_range(0, 9)));
            for (int n = 0; n < 250; n++) random_beat(75);
            drain();
        end

        // Extremes of the setup registers
        write_setup(CFG_CYCLES_PER_LINE, 16'hffff);
        write_setup(CFG_LINES_PER_FRAME, 16'h3ff);
        write_setup(CFG_VBLANK_START, 16'h3ff);
        for (int n = 0; n < 150; n++) random_beat(60);
        drain();

        write_setup(CFG_CYCLES_PER_LINE, 16'd1);
        write_setup(CFG_LINES_PER_FRAME, 16'd1);
        write_setup(CFG_VBLANK_START, 16'd1);
        for (int n = 0; n < 100; n++) random_beat(80);
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
